// ===== hdl/l1ag_pkg.sv =====
package l1ag_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int THR_W      = 17;
    localparam int THR_CNT_W  = 5;
    localparam int MAG_SHIFT  = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_CHECK_ENABLE    = 2'd0;
    localparam logic [1:0] REG_RATIO_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_USE_MAGNITUDE   = 2'd2;

    localparam logic             RST_CHECK_ENABLE    = 1'b1;
    localparam logic [THR_W-1:0] RST_RATIO_THRESHOLD = 17'd29491;
    localparam logic             RST_USE_MAGNITUDE   = 1'b1;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] roll_angle;
    } in_item_t;

    typedef struct packed {
        logic accept;
        logic window_full;
    } out_item_t;

    typedef struct packed {
        logic clr;
        logic vld;
        logic to_bt;
    } mac_ctl_t;

endpackage

// ===== hdl/l1ag_win_mem.sv =====
module l1ag_win_mem #(
    parameter int DEPTH  = 20,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hdl/l1ag_mac.sv =====
module l1ag_mac #(
    parameter int DEV_W = 22,
    parameter int ACC_W = 51
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  l1ag_pkg::mac_ctl_t      ctl,
    input  logic signed [DEV_W-1:0] op_a,
    input  logic signed [DEV_W-1:0] op_b,
    output logic signed [ACC_W-1:0] up,
    output logic signed [ACC_W-1:0] bt
);
    import l1ag_pkg::*;

    localparam int PROD_W = 2 * DEV_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_bt_reg;
    logic signed [ACC_W-1:0]  up_reg;
    logic signed [ACC_W-1:0]  bt_reg;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else if (ctl.clr) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.vld;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= op_a * op_b;
        prod_bt_reg <= ctl.to_bt;
        if (ctl.clr) begin
            up_reg <= '0;
            bt_reg <= '0;
        end else if (prod_vld_reg) begin
            if (prod_bt_reg) begin
                bt_reg <= bt_reg + prod_ext;
            end else begin
                up_reg <= up_reg + prod_ext;
            end
        end
    end

    assign up = up_reg;
    assign bt = bt_reg;
endmodule

// ===== hdl/lag1_autocorrelation_gate_core.sv =====
// channel  | ports                        | moves
// ---------+------------------------------+-------------------------------
// input    | s_valid s_ready s_data       | pitch and roll angle item
// result   | m_valid m_ready m_data       | accept and window_full item
// config   | psel penable pwrite paddr .. | check_enable, threshold, magnitude
//
// full window: one multiplier doing four products per entry, after a sum pass
// over every entry, then a 17-step shift-add threshold multiply; disabled and
// window-filling items skip all of these
// one item at a time; s_ready high only while the sequencer is idle
// a finished item waits in the output register while the next item is taken
// synchronous active-low reset clears the state, window fill and output valid
module lag1_autocorrelation_gate_core #(
    parameter int WINDOW_LEN = 20
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  l1ag_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output l1ag_pkg::out_item_t                  m_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [l1ag_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [l1ag_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [l1ag_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import l1ag_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = ANGLE_BITS + CNT_W;
    localparam int DEV_W  = ANGLE_BITS + CNT_W + 1;
    localparam int ACC_W  = 2 * DEV_W + CNT_W + 2;
    localparam int CMP_W  = ACC_W + THR_W + 1;
    localparam int DATA_W = 2 * ANGLE_BITS;

    typedef enum logic [15:0] {
        ST_IDLE    = 16'b0000_0000_0000_0001,
        ST_WRITE   = 16'b0000_0000_0000_0010,
        ST_SUM_RD  = 16'b0000_0000_0000_0100,
        ST_SUM_ACC = 16'b0000_0000_0000_1000,
        ST_LOAD    = 16'b0000_0000_0001_0000,
        ST_DEV     = 16'b0000_0000_0010_0000,
        ST_M0      = 16'b0000_0000_0100_0000,
        ST_M1      = 16'b0000_0000_1000_0000,
        ST_M2      = 16'b0000_0001_0000_0000,
        ST_M3      = 16'b0000_0010_0000_0000,
        ST_FLUSH   = 16'b0000_0100_0000_0000,
        ST_CHECK   = 16'b0000_1000_0000_0000,
        ST_THR     = 16'b0001_0000_0000_0000,
        ST_CMP     = 16'b0010_0000_0000_0000,
        ST_DONE    = 16'b0100_0000_0000_0000,
        ST_SPARE   = 16'b1000_0000_0000_0000
    } state_t;

    localparam logic signed [DEV_W-1:0] N_DEV = DEV_W'(WINDOW_LEN);

    state_t                   state_reg, state_next;
    in_item_t                 in_reg, in_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         ptr_reg, ptr_next;
    logic [IDX_W-1:0]         oldest_reg, oldest_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic signed [SUM_W-1:0]  sum_p_reg, sum_p_next;
    logic signed [SUM_W-1:0]  sum_r_reg, sum_r_next;
    logic signed [DEV_W-1:0]  dp_reg, dp_next;
    logic signed [DEV_W-1:0]  dr_reg, dr_next;
    logic signed [DEV_W-1:0]  prev_p_reg, prev_p_next;
    logic signed [DEV_W-1:0]  prev_r_reg, prev_r_next;
    logic signed [CMP_W-1:0]  rhs_reg, rhs_next;
    logic signed [CMP_W-1:0]  bt_sh_reg, bt_sh_next;
    logic [THR_W-1:0]         thr_sh_reg, thr_sh_next;
    logic [THR_CNT_W-1:0]     thr_cnt_reg, thr_cnt_next;
    out_item_t                res_reg, res_next;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg, m_data_next;

    logic                     check_enable_reg;
    logic [THR_W-1:0]         ratio_threshold_reg;
    logic                     use_magnitude_reg;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [IDX_W-1:0]         rd_addr;
    logic [DATA_W-1:0]        rd_raw;
    in_item_t                 rd_item;
    logic [CNT_W:0]           slot_sum;
    logic [IDX_W-1:0]         fill_slot;
    logic [IDX_W-1:0]         oldest_inc;
    logic [IDX_W-1:0]         ptr_inc;
    logic signed [DEV_W-1:0]  xp_ext, xr_ext;
    logic signed [ACC_W-1:0]  up, bt;
    logic signed [ACC_W-1:0]  up_sel;
    logic signed [CMP_W-1:0]  lhs;
    mac_ctl_t                 mac_ctl;
    logic signed [DEV_W-1:0]  op_a, op_b;
    logic                     cfg_wr;

    l1ag_win_mem #(
        .DEPTH  (WINDOW_LEN),
        .DATA_W (DATA_W),
        .ADDR_W (IDX_W)
    ) u_win_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    l1ag_mac #(
        .DEV_W (DEV_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .up      (up),
        .bt      (bt)
    );

    assign rd_item  = in_item_t'(rd_raw);
    assign xp_ext   = DEV_W'(rd_item.pitch_angle);
    assign xr_ext   = DEV_W'(rd_item.roll_angle);
    assign slot_sum = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(fill_reg);
    assign fill_slot = (slot_sum >= (CNT_W + 1)'(WINDOW_LEN))
                     ? IDX_W'(slot_sum - (CNT_W + 1)'(WINDOW_LEN)) : IDX_W'(slot_sum);
    assign oldest_inc = (oldest_reg == IDX_W'(WINDOW_LEN - 1)) ? '0 : oldest_reg + 1'b1;
    assign ptr_inc    = (ptr_reg == IDX_W'(WINDOW_LEN - 1)) ? '0 : ptr_reg + 1'b1;
    assign rd_addr    = ptr_reg;
    assign up_sel     = (use_magnitude_reg && up[ACC_W-1]) ? -up : up;
    assign lhs        = CMP_W'(up_sel) <<< MAG_SHIFT;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = fill_slot;
        if (state_reg == ST_WRITE) begin
            wr_en = 1'b1;
            if (fill_reg == CNT_W'(WINDOW_LEN)) begin
                wr_addr = oldest_reg;
            end
        end
    end

    always_comb begin
        mac_ctl = '0;
        op_a    = dp_reg;
        op_b    = dp_reg;
        case (state_reg)
            ST_WRITE: begin
                mac_ctl.clr = 1'b1;
            end
            ST_M0: begin
                mac_ctl.vld   = 1'b1;
                mac_ctl.to_bt = 1'b1;
            end
            ST_M1: begin
                op_b        = prev_p_reg;
                mac_ctl.vld = (idx_reg != '0);
            end
            ST_M2: begin
                op_a          = dr_reg;
                op_b          = dr_reg;
                mac_ctl.vld   = 1'b1;
                mac_ctl.to_bt = 1'b1;
            end
            ST_M3: begin
                op_a        = dr_reg;
                op_b        = prev_r_reg;
                mac_ctl.vld = (idx_reg != '0);
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        in_next      = in_reg;
        idx_next     = idx_reg;
        ptr_next     = ptr_reg;
        oldest_next  = oldest_reg;
        fill_next    = fill_reg;
        sum_p_next   = sum_p_reg;
        sum_r_next   = sum_r_reg;
        dp_next      = dp_reg;
        dr_next      = dr_reg;
        prev_p_next  = prev_p_reg;
        prev_r_next  = prev_r_reg;
        rhs_next     = rhs_reg;
        bt_sh_next   = bt_sh_reg;
        thr_sh_next  = thr_sh_reg;
        thr_cnt_next = thr_cnt_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next = s_data;
                    if (!check_enable_reg) begin
                        res_next   = '{accept: 1'b1, window_full: 1'b0};
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                if (fill_reg != CNT_W'(WINDOW_LEN)) begin
                    fill_next  = fill_reg + 1'b1;
                    res_next   = '{accept: 1'b1, window_full: 1'b0};
                    state_next = ST_DONE;
                end else begin
                    oldest_next = oldest_inc;
                    ptr_next    = oldest_inc;
                    idx_next    = '0;
                    sum_p_next  = '0;
                    sum_r_next  = '0;
                    state_next  = ST_SUM_RD;
                end
            end
            ST_SUM_RD: begin
                state_next = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                sum_p_next = sum_p_reg + SUM_W'(rd_item.pitch_angle);
                sum_r_next = sum_r_reg + SUM_W'(rd_item.roll_angle);
                ptr_next   = ptr_inc;
                if (idx_reg == IDX_W'(WINDOW_LEN - 1)) begin
                    idx_next   = '0;
                    state_next = ST_LOAD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SUM_RD;
                end
            end
            ST_LOAD: begin
                state_next = ST_DEV;
            end
            ST_DEV: begin
                dp_next    = xp_ext * N_DEV - DEV_W'(sum_p_reg);
                dr_next    = xr_ext * N_DEV - DEV_W'(sum_r_reg);
                state_next = ST_M0;
            end
            ST_M0: begin
                state_next = ST_M1;
            end
            ST_M1: begin
                state_next = ST_M2;
            end
            ST_M2: begin
                state_next = ST_M3;
            end
            ST_M3: begin
                prev_p_next = dp_reg;
                prev_r_next = dr_reg;
                ptr_next    = ptr_inc;
                if (idx_reg == IDX_W'(WINDOW_LEN - 1)) begin
                    state_next = ST_FLUSH;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_FLUSH: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (bt == '0) begin
                    res_next   = '{accept: 1'b1, window_full: 1'b1};
                    state_next = ST_DONE;
                end else begin
                    rhs_next     = '0;
                    bt_sh_next   = CMP_W'(bt);
                    thr_sh_next  = ratio_threshold_reg;
                    thr_cnt_next = '0;
                    state_next   = ST_THR;
                end
            end
            ST_THR: begin
                if (thr_sh_reg[0]) begin
                    rhs_next = rhs_reg + bt_sh_reg;
                end
                bt_sh_next   = bt_sh_reg <<< 1;
                thr_sh_next  = thr_sh_reg >> 1;
                thr_cnt_next = thr_cnt_reg + 1'b1;
                if (thr_cnt_reg == THR_CNT_W'(THR_W - 1)) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                res_next   = '{accept: !(lhs >= rhs_reg), window_full: 1'b1};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            oldest_reg  <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        idx_reg     <= idx_next;
        ptr_reg     <= ptr_next;
        sum_p_reg   <= sum_p_next;
        sum_r_reg   <= sum_r_next;
        dp_reg      <= dp_next;
        dr_reg      <= dr_next;
        prev_p_reg  <= prev_p_next;
        prev_r_reg  <= prev_r_next;
        rhs_reg     <= rhs_next;
        bt_sh_reg   <= bt_sh_next;
        thr_sh_reg  <= thr_sh_next;
        thr_cnt_reg <= thr_cnt_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    // configuration registers
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_enable_reg    <= RST_CHECK_ENABLE;
            ratio_threshold_reg <= RST_RATIO_THRESHOLD;
            use_magnitude_reg   <= RST_USE_MAGNITUDE;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_CHECK_ENABLE:    check_enable_reg    <= pwdata[0];
                REG_RATIO_THRESHOLD: ratio_threshold_reg <= pwdata[THR_W-1:0];
                REG_USE_MAGNITUDE:   use_magnitude_reg   <= pwdata[0];
                default: begin
                    check_enable_reg <= check_enable_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CHECK_ENABLE:    prdata = APB_DATA_W'(check_enable_reg);
            REG_RATIO_THRESHOLD: prdata = APB_DATA_W'(ratio_threshold_reg);
            REG_USE_MAGNITUDE:   prdata = APB_DATA_W'(use_magnitude_reg);
            default:             prdata = '0;
        endcase
    end

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
